// File: rtl/dsm_pkg.sv
// Shared types, constants and the byte-to-base mapping for the DNA site matcher.
`timescale 1ns / 1ps
`default_nettype none

package dsm_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 3;
    localparam int CODE_SLOTS  = 16;
    localparam int CODES_W     = CODE_W * CODE_SLOTS;
    localparam int LEN_W       = 5;
    localparam int RESULT_W    = 32;
    localparam int CFG_INDEX_W = 4;

    // Base codes.
    localparam logic [CODE_W-1:0] CODE_A        = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C        = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G        = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T        = 3'd3;
    localparam logic [CODE_W-1:0] NO_MATCH_CODE = 3'd4;
    localparam logic [CODE_W-1:0] GAP_CODE      = 3'd5;
    localparam logic [CODE_W-1:0] BAD_CODE_6    = 3'd6;
    localparam logic [CODE_W-1:0] BAD_CODE_7    = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_CODES  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 4'd1;

    // Reset values of the configuration registers.
    localparam logic [CODES_W-1:0] PATTERN_CODES_RESET  = '0;
    localparam logic [LEN_W-1:0]   PATTERN_LENGTH_RESET = 5'd4;

    // Pattern as seen by the comparator.
    typedef struct packed {
        logic [CODES_W-1:0] codes;
        logic [LEN_W-1:0]   len;
        logic               invalid;
    } pattern_t;

    // Maps a raw sequence character to its base code.
    function automatic logic [CODE_W-1:0] map_base(input logic [BYTE_W-1:0] b);
        logic [CODE_W-1:0] code;
        case (b)
            8'h41, 8'h61: code = CODE_A;
            8'h43, 8'h63: code = CODE_C;
            8'h47, 8'h67: code = CODE_G;
            8'h54, 8'h74: code = CODE_T;
            8'h2D:        code = GAP_CODE;
            default:      code = NO_MATCH_CODE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dsm_cfg_regs.sv
// Configuration registers of the site pattern and its derived length and validity.
`timescale 1ns / 1ps
`default_nettype none

module dsm_cfg_regs #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [dsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dsm_pkg::CODES_W-1:0]     cfg_data,
    output dsm_pkg::pattern_t                    pattern
);

    // Longest pattern the matcher can hold.
    localparam int CAP = (MAX_PATTERN < dsm_pkg::CODE_SLOTS) ? MAX_PATTERN
                                                            : dsm_pkg::CODE_SLOTS;

    logic [dsm_pkg::CODES_W-1:0] codes_reg;
    logic [dsm_pkg::LEN_W-1:0]   length_reg;
    logic [dsm_pkg::LEN_W-1:0]   eff_len;
    logic                        invalid;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg  <= dsm_pkg::PATTERN_CODES_RESET;
            length_reg <= dsm_pkg::PATTERN_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dsm_pkg::CFG_PATTERN_CODES:  codes_reg  <= cfg_data;
                dsm_pkg::CFG_PATTERN_LENGTH: length_reg <= cfg_data[dsm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Length is capped at what the history and the code field can hold.
    assign eff_len = (length_reg > dsm_pkg::LEN_W'(CAP)) ? dsm_pkg::LEN_W'(CAP) : length_reg;

    // A pattern with the no-match code or code 6 or 7 among its used bases is invalid.
    always_comb
    begin
        logic [dsm_pkg::CODE_W-1:0] p;
        invalid = 1'b0;
        for (int k = 0; k < CAP; k++)
        begin
            p = codes_reg[k*dsm_pkg::CODE_W +: dsm_pkg::CODE_W];
            if ((dsm_pkg::LEN_W'(k) < eff_len) &&
                (p == dsm_pkg::NO_MATCH_CODE || p == dsm_pkg::BAD_CODE_6 ||
                 p == dsm_pkg::BAD_CODE_7))
            begin
                invalid = 1'b1;
            end
        end
    end

    assign pattern.codes   = codes_reg;
    assign pattern.len     = eff_len;
    assign pattern.invalid = invalid;

endmodule

`default_nettype wire

// File: rtl/dsm_compare.sv
// Parallel compare of the base window against the reversed site pattern.
`timescale 1ns / 1ps
`default_nettype none

module dsm_compare #(
    parameter int CAP = 16
) (
    input  wire logic [CAP-1:0][dsm_pkg::CODE_W-1:0] window,
    input  wire dsm_pkg::pattern_t                   pattern,
    output logic                                     match
);

    // Window slot k (k = 0 is the newest base) meets pattern base len-1-k.
    always_comb
    begin
        logic                        all_eq;
        logic [dsm_pkg::LEN_W-1:0]   sel;
        logic [dsm_pkg::CODE_W-1:0]  p;
        all_eq = 1'b1;
        for (int k = 0; k < CAP; k++)
        begin
            sel = pattern.len - dsm_pkg::LEN_W'(k) - dsm_pkg::LEN_W'(1);
            p   = dsm_pkg::CODE_W'(pattern.codes >> (7'(sel) * 7'd3));
            if ((dsm_pkg::LEN_W'(k) < pattern.len) && (window[k] != p))
            begin
                all_eq = 1'b0;
            end
        end
        match = (pattern.len != '0) && !pattern.invalid && all_eq;
    end

endmodule

`default_nettype wire

// File: rtl/dsm_site_matcher_core.sv
// Sequence state (base history, position, site count) and the result register.
`timescale 1ns / 1ps
`default_nettype none

module dsm_site_matcher_core #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [dsm_pkg::CODE_W-1:0]   code,
    input  wire logic                         restart,
    input  wire dsm_pkg::pattern_t            pattern,
    output logic                              site_found,
    output logic [dsm_pkg::RESULT_W-1:0]      site_start,
    output logic [dsm_pkg::RESULT_W-1:0]      site_total,
    output logic                              pattern_invalid
);

    localparam int CAP    = (MAX_PATTERN < dsm_pkg::CODE_SLOTS) ? MAX_PATTERN
                                                               : dsm_pkg::CODE_SLOTS;
    localparam int HIST_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int WIDE   = (POSITION_BITS > dsm_pkg::RESULT_W) ? POSITION_BITS
                                                               : dsm_pkg::RESULT_W;
    localparam logic [POSITION_BITS-1:0]    POS_MAX   = '1;
    localparam logic [dsm_pkg::RESULT_W-1:0] COUNT_MAX = '1;

    logic [HIST_D-1:0][dsm_pkg::CODE_W-1:0] hist_reg, hist_next, hist_eff;
    logic [POSITION_BITS-1:0]               pos_reg, pos_next, pos_eff;
    logic [dsm_pkg::RESULT_W-1:0]           count_reg, count_next, count_eff;
    logic [CAP-1:0][dsm_pkg::CODE_W-1:0]    window;
    logic                                   match;
    logic [WIDE-1:0]                        start_wide;

    logic                                   found_reg;
    logic [dsm_pkg::RESULT_W-1:0]           start_reg;
    logic [dsm_pkg::RESULT_W-1:0]           total_reg;
    logic                                   invalid_reg;

    // A new sequence starts from cleared history, position and count.
    always_comb
    begin
        for (int i = 0; i < HIST_D; i++)
        begin
            hist_eff[i] = restart ? dsm_pkg::NO_MATCH_CODE : hist_reg[i];
        end
        pos_eff   = restart ? '0 : pos_reg;
        count_eff = restart ? '0 : count_reg;
    end

    // Compare window: this base, then the history, newest first.
    assign window[0] = code;
    for (genvar k = 1; k < CAP; k++)
    begin : g_window
        assign window[k] = hist_eff[k-1];
    end

    dsm_compare #(
        .CAP (CAP)
    ) u_compare (
        .window  (window),
        .pattern (pattern),
        .match   (match)
    );

    // Next sequence state.
    always_comb
    begin
        if (MAX_PATTERN > 1)
        begin
            hist_next[0] = code;
            for (int i = 1; i < HIST_D; i++)
            begin
                hist_next[i] = hist_eff[i-1];
            end
        end
        else
        begin
            hist_next = hist_eff;
        end
        pos_next   = (pos_eff == POS_MAX) ? pos_eff : pos_eff + POSITION_BITS'(1);
        count_next = (match && count_eff != COUNT_MAX) ? count_eff + dsm_pkg::RESULT_W'(1)
                                                       : count_eff;
    end

    // Start of the site: position of this base minus length plus one.
    assign start_wide = WIDE'(pos_eff) - WIDE'(pattern.len) + WIDE'(1);

    // State and result registers advance together with each request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_D; i++)
            begin
                hist_reg[i] <= dsm_pkg::NO_MATCH_CODE;
            end
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            hist_reg  <= hist_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            found_reg   <= match;
            start_reg   <= match ? start_wide[dsm_pkg::RESULT_W-1:0] : '0;
            total_reg   <= count_next;
            invalid_reg <= pattern.invalid;
        end
    end

    assign site_found      = found_reg;
    assign site_start      = start_reg;
    assign site_total      = total_reg;
    assign pattern_invalid = invalid_reg;

endmodule

`default_nettype wire

// File: rtl/dna_site_matcher.sv
// Top level of the streaming DNA site matcher.
//
// Usage: sequence bytes enter as requests on the in_valid/in_ready channel
// (base_byte, sequence_start); each request yields exactly one result on the
// out_valid/out_ready channel (site_found, site_start, site_total,
// pattern_invalid). sequence_start marks the first byte of a new sequence and
// clears the base history, the position and the site count before that byte.
// The site pattern is written through the cfg_valid/cfg_ready port, index 0
// for pattern_codes and index 1 for pattern_length; the user must write it only
// while the block idles, which the block itself does not enforce. cfg_ready is always high.
// An accepted request waits in the input register; the compare works on the input
// register and loads the result register when the result register is free.
// Throughput is one request per cycle while the receiver takes the results, set by
// the combinational parallel compare of the pattern against the history register.
// When the receiver stalls, the result register holds and the input register
// keeps one more request; in_ready then drops until the result is taken.
// Reset clears the pipeline, the history (to the no-match code), the position
// and the count, and loads pattern_codes = 0 and pattern_length = 4.
`timescale 1ns / 1ps
`default_nettype none

module dna_site_matcher #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [dsm_pkg::BYTE_W-1:0]      base_byte,
    input  wire logic                            sequence_start,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 site_found,
    output logic [dsm_pkg::RESULT_W-1:0]         site_start,
    output logic [dsm_pkg::RESULT_W-1:0]         site_total,
    output logic                                 pattern_invalid,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dsm_pkg::CODES_W-1:0]     cfg_data
);

    dsm_pkg::pattern_t             pattern;
    logic                          in_valid_reg;
    logic [dsm_pkg::CODE_W-1:0]    code_reg;
    logic                          start_reg;
    logic                          out_valid_reg;
    logic                          step;

    assign cfg_ready = 1'b1;

    dsm_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern)
    );

    // Handshake: the input stage moves on when the result register is free.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register holds the mapped base code of the request.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg  <= dsm_pkg::map_base(base_byte);
            start_reg <= sequence_start;
        end
    end

    dsm_site_matcher_core #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .code            (code_reg),
        .restart         (start_reg),
        .pattern         (pattern),
        .site_found      (site_found),
        .site_start      (site_start),
        .site_total      (site_total),
        .pattern_invalid (pattern_invalid)
    );

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
